[sv/peth_pkg.sv]
// Shared types, constants and helper functions for the peri-event time histogram.
// Used by peth_ctrl, peth_dpath and peri_event_time_histogram_top. No dependencies.
package peth_pkg;

  // Table geometry.
  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 32;
  localparam int BIN_BITS   = $clog2(NUM_BINS);

  // Field widths fixed by the interface.
  localparam int TIME_BITS = 32;
  localparam int IDX_BITS  = 8;
  localparam int REP_BITS  = 32;
  localparam int STEP_BITS = $clog2(TIME_BITS);

  // Request operations.
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_VISIT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_BIN = 2'd0;
  localparam logic [1:0] CFG_BIN_RES = 2'd1;

  localparam logic [IDX_BITS-1:0]  MAX_BIN_RST = 8'd255;
  localparam logic [TIME_BITS-1:0] BIN_RES_RST = 32'd65536;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_EV_RD,
    ST_EV_WR,
    ST_VI_RD,
    ST_VI_WR,
    ST_RD_ADDR,
    ST_RD_OUT
  } peth_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic bin_inc;
    logic bin_clear;
    logic in_load;
    logic div_start;
    logic div_step;
    logic ev_rd;
    logic ev_wr;
    logic vi_rd;
    logic vi_wr;
    logic rd_rd;
    logic out_load;
  } peth_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       div_last;
    logic       bin_last;
    logic       clr_last;
    logic       out_busy;
  } peth_sts_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
  endfunction

  // Clamp a count to the width of the result fields.
  function automatic logic [REP_BITS-1:0] report(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? {REP_BITS{1'b1}} : w[REP_BITS-1:0];
  endfunction

endpackage

[sv/peth_ctrl.sv]
// Controller state machine of the peri-event time histogram.
// Depends on peth_pkg; drives the command struct of peth_dpath.
module peth_ctrl import peth_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [1:0] op_i,
  input  logic      out_ready_i,
  input  peth_sts_t sts_i,
  output logic      in_ready_o,
  output peth_cmd_t cmd_o
);

  peth_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_EVENT, OP_VISIT: state_d = ST_DIV;
            OP_READ:            state_d = ST_RD_ADDR;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) state_d = (sts_i.op == OP_EVENT) ? ST_EV_RD : ST_VI_RD;
      end
      ST_EV_RD:   state_d = ST_EV_WR;
      ST_EV_WR:   state_d = ST_IDLE;
      ST_VI_RD:   state_d = ST_VI_WR;
      ST_VI_WR: begin
        state_d = sts_i.bin_last ? ST_IDLE : ST_VI_RD;
      end
      ST_RD_ADDR: state_d = ST_RD_OUT;
      ST_RD_OUT: begin
        if (!sts_i.out_busy || out_ready_i) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.bin_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.in_load   = in_valid_i;
        cmd_o.div_start = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.bin_clear = sts_i.div_last;
      end
      ST_EV_RD:   cmd_o.ev_rd = 1'b1;
      ST_EV_WR:   cmd_o.ev_wr = 1'b1;
      ST_VI_RD:   cmd_o.vi_rd = 1'b1;
      ST_VI_WR: begin
        cmd_o.vi_wr   = 1'b1;
        cmd_o.bin_inc = 1'b1;
      end
      ST_RD_ADDR: cmd_o.rd_rd = 1'b1;
      ST_RD_OUT:  cmd_o.out_load = !sts_i.out_busy || out_ready_i;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // A result is only loaded when the output register is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!sts_i.out_busy || out_ready_i))
    else $error("result loaded over an unread result");

  // No request is taken while the tables are being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("request accepted during table clear");

  // Every table write-back follows the read of the same entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ev_wr |-> $past(cmd_o.ev_rd))
    else $error("response write without preceding read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.vi_wr |-> $past(cmd_o.vi_rd))
    else $error("visit write without preceding read");

endmodule

[sv/peth_dpath.sv]
// Datapath of the peri-event time histogram: config registers, serial divider,
// the two count tables and the result register. Depends on peth_pkg.
module peth_dpath import peth_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [TIME_BITS-1:0]  cfg_wdata_i,
  input  logic [1:0]            op_i,
  input  logic [TIME_BITS-1:0]  time_value_i,
  input  logic [IDX_BITS-1:0]   read_bin_i,
  input  logic                  out_ready_i,
  input  peth_cmd_t             cmd_i,
  output peth_sts_t             sts_o,
  output logic                  out_valid_o,
  output logic [IDX_BITS-1:0]   bin_index_o,
  output logic [REP_BITS-1:0]   visit_count_o,
  output logic [REP_BITS-1:0]   response_count_o
);

  // Configuration registers.
  logic [IDX_BITS-1:0]  max_bin_q;
  logic [TIME_BITS-1:0] bin_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bin_q <= MAX_BIN_RST;
      bin_res_q <= BIN_RES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_BIN: max_bin_q <= cfg_wdata_i[IDX_BITS-1:0];
        CFG_BIN_RES: bin_res_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Captured request.
  logic [1:0]          op_q;
  logic [IDX_BITS-1:0] rb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q <= op_i;
      rb_q <= read_bin_i;
    end
  end

  // Restoring divider, one quotient bit per cycle. A zero resolution divides by one.
  logic [TIME_BITS-1:0] rem_q, quo_q, dvs_q;
  logic [STEP_BITS-1:0] step_q;
  logic [TIME_BITS:0]   shifted;
  logic [TIME_BITS+1:0] diff;

  assign shifted = {rem_q, quo_q[TIME_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= time_value_i;
      dvs_q  <= (bin_res_q == '0) ? TIME_BITS'(1) : bin_res_q;
      step_q <= STEP_BITS'(TIME_BITS - 1);
    end else if (cmd_i.div_step) begin
      if (!diff[TIME_BITS+1]) begin
        rem_q <= diff[TIME_BITS-1:0];
        quo_q <= {quo_q[TIME_BITS-2:0], 1'b1};
      end else begin
        rem_q <= shifted[TIME_BITS-1:0];
        quo_q <= {quo_q[TIME_BITS-2:0], 1'b0};
      end
      step_q <= step_q - STEP_BITS'(1);
    end
  end

  // Highest counted bin and the last bin a visit reaches.
  logic [TIME_BITS-1:0] top, last;
  logic                 ev_in_range;

  assign top = (32'(max_bin_q) < 32'(NUM_BINS - 1)) ? 32'(max_bin_q) : 32'(NUM_BINS - 1);
  assign last        = (quo_q < top) ? quo_q : top;
  assign ev_in_range = (quo_q <= top);

  // Sweep counter for clearing and for visit updates.
  logic [BIN_BITS-1:0] bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
    end else if (cmd_i.bin_clear) begin
      bin_q <= '0;
    end else if (cmd_i.bin_inc) begin
      bin_q <= bin_q + BIN_BITS'(1);
    end
  end

  // Count tables.
  logic [COUNT_BITS-1:0] resp_mem [NUM_BINS];
  logic [COUNT_BITS-1:0] vis_mem  [NUM_BINS];
  logic [COUNT_BITS-1:0] resp_rd_q, vis_rd_q;
  logic [BIN_BITS-1:0]   rb_addr, ev_addr, resp_addr, vis_addr;
  logic                  resp_we, vis_we;
  logic [COUNT_BITS-1:0] resp_wdata, vis_wdata;

  assign rb_addr = BIN_BITS'(rb_q);
  assign ev_addr = BIN_BITS'(quo_q);

  always_comb begin
    if (cmd_i.ev_rd || cmd_i.ev_wr) begin
      resp_addr = ev_addr;
    end else if (cmd_i.rd_rd) begin
      resp_addr = rb_addr;
    end else begin
      resp_addr = bin_q;
    end
  end

  assign vis_addr   = cmd_i.rd_rd ? rb_addr : bin_q;
  assign resp_we    = cmd_i.clr_wr || (cmd_i.ev_wr && ev_in_range);
  assign vis_we     = cmd_i.clr_wr || cmd_i.vi_wr;
  assign resp_wdata = cmd_i.clr_wr ? '0 : sat_inc(resp_rd_q);
  assign vis_wdata  = cmd_i.clr_wr ? '0 : sat_inc(vis_rd_q);

  always_ff @(posedge clk_i) begin
    if (resp_we) resp_mem[resp_addr] <= resp_wdata;
    if (cmd_i.ev_rd || cmd_i.rd_rd) resp_rd_q <= resp_mem[resp_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_addr] <= vis_wdata;
    if (cmd_i.vi_rd || cmd_i.rd_rd) vis_rd_q <= vis_mem[vis_addr];
  end

  // Result register.
  logic                rb_in_range;
  logic                out_valid_q;
  logic [IDX_BITS-1:0] bin_index_q;
  logic [REP_BITS-1:0] visit_q, resp_q;

  assign rb_in_range = (32'(rb_q) < 32'(NUM_BINS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bin_index_q <= rb_q;
      visit_q     <= rb_in_range ? report(vis_rd_q) : '0;
      resp_q      <= rb_in_range ? report(resp_rd_q) : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bin_index_o      = bin_index_q;
  assign visit_count_o    = visit_q;
  assign response_count_o = resp_q;

  assign sts_o.op       = op_q;
  assign sts_o.div_last = (step_q == '0);
  assign sts_o.bin_last = (32'(bin_q) == last);
  assign sts_o.clr_last = (bin_q == BIN_BITS'(NUM_BINS - 1));
  assign sts_o.out_busy = out_valid_q;

endmodule

[sv/peri_event_time_histogram_top.sv]
// An event or visit request first passes through the 32-step serial divider. An event
// then does one read-modify-write of its table entry if it is in range, a visit one per
// bin from zero up to the last bin, and a read fills the result register from both tables.
// One request is in work at a time; the result register lets the next request in
// while a result waits. After reset the tables are cleared, during which no request
// is taken; configuration writes are taken at any time.
module peri_event_time_histogram_top import peth_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port: index 0 is max_bin, index 1 is the bin width.
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [TIME_BITS-1:0] cfg_wdata_i,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [TIME_BITS-1:0] time_value_i,
  input  logic [IDX_BITS-1:0]  read_bin_i,
  // Result channel, one result per read request.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_BITS-1:0]  bin_index_o,
  output logic [REP_BITS-1:0]  visit_count_o,
  output logic [REP_BITS-1:0]  response_count_o
);

  // The controller sequences the clear sweep, the divider steps and the table
  // updates; the datapath holds all storage and arithmetic.
  peth_cmd_t cmd;
  peth_sts_t sts;

  peth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // The bin of a time value is its integer quotient by the resolution. A visit
  // sweeps bins from zero up to that quotient, clipped to the counted range.
  peth_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .time_value_i     (time_value_i),
    .read_bin_i       (read_bin_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .bin_index_o      (bin_index_o),
    .visit_count_o    (visit_count_o),
    .response_count_o (response_count_o)
  );

endmodule
